>>> rtl/core/dls_pkg.sv
// dls_pkg: shared widths, codes, reset levels and control types for the dual link selector
// no dependencies; imported by dls_avg_div and dual_link_selector
`default_nettype none

package dls_pkg;

   localparam int WIFI_W     = 8;
   localparam int LTE_W      = 9;
   localparam int SEL_W      = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;

   typedef enum logic [SEL_W-1:0] {
      SEL_BOTH = 2'd0,
      SEL_WIFI = 2'd1,
      SEL_LTE  = 2'd2
   } sel_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIFI_MID   = 3'd0,
      CSR_WIFI_GOOD  = 3'd1,
      CSR_LTE_MID    = 3'd2,
      CSR_LTE_GOOD   = 3'd3,
      CSR_FORCE_BOTH = 3'd4
   } csr_idx_type;

   localparam logic signed [WIFI_W-1:0] WIFI_MID_RST  = -8'sd70;
   localparam logic signed [WIFI_W-1:0] WIFI_GOOD_RST = -8'sd65;
   localparam logic signed [LTE_W-1:0]  LTE_MID_RST   = -9'sd90;
   localparam logic signed [LTE_W-1:0]  LTE_GOOD_RST  = -9'sd80;

   typedef struct packed {
      logic ld_mag;
      logic ld_prd;
   } div_ctl_type;

endpackage

`default_nettype wire

>>> rtl/core/dls_ram.sv
// dls_ram: generic single-clock ram, one write port and one registered read port
// no dependencies
`default_nettype none

module dls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/dls_avg_div.sv
// dls_avg_div: two-stage signed divide of a window sum by the window length
// reciprocal multiply, truncates toward zero; depends on dls_pkg
`default_nettype none

module dls_avg_div
   import dls_pkg::*;
#(
   parameter int IN_W   = 8,
   parameter int WINDOW = 32
) (
   input  wire logic                                  clock,
   input  wire div_ctl_type                           ctl,
   input  wire logic signed [IN_W+$clog2(WINDOW)-1:0] sum,
   output logic signed      [IN_W-1:0]                avg
);

   localparam int LOG_W = $clog2(WINDOW);
   localparam int SUM_W = IN_W + LOG_W;
   localparam int SHIFT = SUM_W + LOG_W;
   localparam int M_W   = SUM_W + 2;
   localparam int PRD_W = SUM_W + M_W;
   localparam logic [M_W-1:0] RECIP =
      M_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

   logic [SUM_W-1:0] sum_neg;
   logic [SUM_W-1:0] mag_in;
   logic [SUM_W-1:0] mag_ff;
   logic             neg_ff;
   logic [PRD_W-1:0] prd_in;
   logic [PRD_W-1:0] prd_ff;
   logic             neg_prd_ff;
   logic [IN_W-1:0]  quot;

   assign sum_neg = ~sum + SUM_W'(1);
   assign mag_in  = sum[SUM_W-1] ? sum_neg : sum;
   assign prd_in  = PRD_W'(mag_ff) * PRD_W'(RECIP);

   always_ff @(posedge clock) begin
      if (ctl.ld_mag) begin
         mag_ff <= mag_in;
         neg_ff <= sum[SUM_W-1];
      end
      if (ctl.ld_prd) begin
         prd_ff     <= prd_in;
         neg_prd_ff <= neg_ff;
      end
   end

   assign quot = prd_ff[SHIFT +: IN_W];
   assign avg  = neg_prd_ff ? -quot : quot;

endmodule

`default_nettype wire

>>> rtl/core/dual_link_selector.sv
// dual_link_selector: windowed wifi/lte signal averages and link selection
// a result passes the ram read, magnitude, product and output registers before it is offered
// throughput: one item per cycle unless stalled, set by one ram read and one ram write per item
// reset: window contents read as zero until each slot is first rewritten (fill flag)
// reset restores the threshold registers; no clearing pass is needed
// depends on dls_pkg, dls_ram, dls_avg_div
`default_nettype none

module dual_link_selector
   import dls_pkg::*;
#(
   parameter int WINDOW = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic signed [WIFI_W-1:0] req_wifi_sample,
   input  wire logic signed [LTE_W-1:0]  req_lte_sample,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [SEL_W-1:0]             rsp_selection,
   output logic signed [WIFI_W-1:0]     rsp_wifi_average,
   output logic signed [LTE_W-1:0]      rsp_lte_average,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_data
);

   localparam int AW     = $clog2(WINDOW);
   localparam int WSUM_W = WIFI_W + AW;
   localparam int LSUM_W = LTE_W + AW;
   localparam int RAM_W  = WIFI_W + LTE_W;
   localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW - 1);

   // handshake and pipeline control
   logic accept;
   logic rmw_go;
   logic ld_out;
   logic rdy_out, rdy_prd, rdy_mag, rdy_rd;
   logic v_rd_ff, v_rd_in;
   logic v_mag_ff, v_mag_in;
   logic v_prd_ff, v_prd_in;
   logic rsp_valid_ff, rsp_valid_in;
   div_ctl_type div_ctl;

   // ring slot and fill tracking
   logic [AW-1:0] slot_ff, slot_in;
   logic          fill_ff, fill_in;

   // read-modify-write stage
   logic [AW-1:0]             wr_slot_ff;
   logic                      old_ok_ff;
   logic signed [WIFI_W-1:0]  new_wifi_ff;
   logic signed [LTE_W-1:0]   new_lte_ff;
   logic [RAM_W-1:0]          rd_data;
   logic [RAM_W-1:0]          wr_data;
   logic signed [WIFI_W-1:0]  old_wifi;
   logic signed [LTE_W-1:0]   old_lte;
   logic signed [WSUM_W-1:0]  wifi_sum_ff, wifi_sum_in;
   logic signed [LSUM_W-1:0]  lte_sum_ff, lte_sum_in;

   // averages and selection
   logic signed [WIFI_W-1:0]  wifi_avg;
   logic signed [LTE_W-1:0]   lte_avg;
   logic                      w_good, w_mid, l_good, l_mid;
   logic                      wifi_only, lte_only;
   sel_type                   sel_in;
   sel_type                   sel_ff;
   logic signed [WIFI_W-1:0]  wifi_avg_ff;
   logic signed [LTE_W-1:0]   lte_avg_ff;

   // configuration registers
   logic signed [WIFI_W-1:0]  wifi_mid_ff, wifi_mid_in;
   logic signed [WIFI_W-1:0]  wifi_good_ff, wifi_good_in;
   logic signed [LTE_W-1:0]   lte_mid_ff, lte_mid_in;
   logic signed [LTE_W-1:0]   lte_good_ff, lte_good_in;
   logic                      force_both_ff, force_both_in;

   assign rdy_out   = !rsp_valid_ff || !rsp_stall;
   assign rdy_prd   = !v_prd_ff || rdy_out;
   assign rdy_mag   = !v_mag_ff || rdy_prd;
   assign rdy_rd    = !v_rd_ff || rdy_mag;
   assign req_stall = !rdy_rd;
   assign accept    = req_valid && rdy_rd;
   assign rmw_go    = v_rd_ff && rdy_mag;
   assign ld_out    = v_prd_ff && rdy_out;

   assign div_ctl.ld_mag = rmw_go;
   assign div_ctl.ld_prd = v_mag_ff && rdy_prd;

   assign v_rd_in      = accept || (v_rd_ff && !rdy_mag);
   assign v_mag_in     = rmw_go || (v_mag_ff && !rdy_prd);
   assign v_prd_in     = div_ctl.ld_prd || (v_prd_ff && !rdy_out);
   assign rsp_valid_in = ld_out || (rsp_valid_ff && rsp_stall);

   always_comb begin
      slot_in = slot_ff;
      fill_in = fill_ff;
      if (accept) begin
         if (slot_ff == LAST_SLOT) begin
            slot_in = '0;
            fill_in = 1'b1;
         end else begin
            slot_in = slot_ff + AW'(1);
         end
      end
   end

   // window entries, wifi in the upper bits
   assign wr_data = {new_wifi_ff, new_lte_ff};

   dls_ram #(
      .WIDTH (RAM_W),
      .DEPTH (WINDOW)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (rmw_go),
      .wr_addr (wr_slot_ff),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (slot_ff),
      .rd_data (rd_data)
   );

   // slots not yet written since reset read as zero
   assign old_wifi = old_ok_ff ? rd_data[RAM_W-1:LTE_W] : '0;
   assign old_lte  = old_ok_ff ? rd_data[LTE_W-1:0] : '0;

   assign wifi_sum_in = wifi_sum_ff
                      + {{AW{new_wifi_ff[WIFI_W-1]}}, new_wifi_ff}
                      - {{AW{old_wifi[WIFI_W-1]}}, old_wifi};
   assign lte_sum_in  = lte_sum_ff
                      + {{AW{new_lte_ff[LTE_W-1]}}, new_lte_ff}
                      - {{AW{old_lte[LTE_W-1]}}, old_lte};

   dls_avg_div #(
      .IN_W   (WIFI_W),
      .WINDOW (WINDOW)
   ) u_wifi_div (
      .clock (clock),
      .ctl   (div_ctl),
      .sum   (wifi_sum_in),
      .avg   (wifi_avg)
   );

   dls_avg_div #(
      .IN_W   (LTE_W),
      .WINDOW (WINDOW)
   ) u_lte_div (
      .clock (clock),
      .ctl   (div_ctl),
      .sum   (lte_sum_in),
      .avg   (lte_avg)
   );

   assign w_good = wifi_avg >= wifi_good_ff;
   assign w_mid  = wifi_avg >= wifi_mid_ff;
   assign l_good = lte_avg >= lte_good_ff;
   assign l_mid  = lte_avg >= lte_mid_ff;

   assign wifi_only = (w_good && !l_good) || (w_mid && !l_mid);
   assign lte_only  = (!w_good && l_good) || (!w_mid && l_mid);

   always_comb begin
      if (force_both_ff) begin
         sel_in = SEL_BOTH;
      end else if (wifi_only) begin
         sel_in = SEL_WIFI;
      end else if (lte_only) begin
         sel_in = SEL_LTE;
      end else begin
         sel_in = SEL_BOTH;
      end
   end

   assign csr_ready = 1'b1;

   always_comb begin
      wifi_mid_in   = wifi_mid_ff;
      wifi_good_in  = wifi_good_ff;
      lte_mid_in    = lte_mid_ff;
      lte_good_in   = lte_good_ff;
      force_both_in = force_both_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WIFI_MID:   wifi_mid_in   = csr_data[WIFI_W-1:0];
            CSR_WIFI_GOOD:  wifi_good_in  = csr_data[WIFI_W-1:0];
            CSR_LTE_MID:    lte_mid_in    = csr_data[LTE_W-1:0];
            CSR_LTE_GOOD:   lte_good_in   = csr_data[LTE_W-1:0];
            CSR_FORCE_BOTH: force_both_in = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_rd_ff       <= 1'b0;
         v_mag_ff      <= 1'b0;
         v_prd_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         slot_ff       <= '0;
         fill_ff       <= 1'b0;
         wifi_sum_ff   <= '0;
         lte_sum_ff    <= '0;
         wifi_mid_ff   <= WIFI_MID_RST;
         wifi_good_ff  <= WIFI_GOOD_RST;
         lte_mid_ff    <= LTE_MID_RST;
         lte_good_ff   <= LTE_GOOD_RST;
         force_both_ff <= 1'b0;
      end else begin
         v_rd_ff       <= v_rd_in;
         v_mag_ff      <= v_mag_in;
         v_prd_ff      <= v_prd_in;
         rsp_valid_ff  <= rsp_valid_in;
         slot_ff       <= slot_in;
         fill_ff       <= fill_in;
         wifi_mid_ff   <= wifi_mid_in;
         wifi_good_ff  <= wifi_good_in;
         lte_mid_ff    <= lte_mid_in;
         lte_good_ff   <= lte_good_in;
         force_both_ff <= force_both_in;
         if (rmw_go) begin
            wifi_sum_ff <= wifi_sum_in;
            lte_sum_ff  <= lte_sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         wr_slot_ff  <= slot_ff;
         old_ok_ff   <= fill_ff;
         new_wifi_ff <= req_wifi_sample;
         new_lte_ff  <= req_lte_sample;
      end
      if (ld_out) begin
         sel_ff      <= sel_in;
         wifi_avg_ff <= wifi_avg;
         lte_avg_ff  <= lte_avg;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_selection    = sel_ff;
   assign rsp_wifi_average = wifi_avg_ff;
   assign rsp_lte_average  = lte_avg_ff;

   a_slot_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && slot_ff == LAST_SLOT |=> slot_ff == '0 && fill_ff)
      else $error("ring slot did not wrap after last entry");

   a_rmw_loaded: assert property (@(posedge clock) disable iff (reset)
      accept |=> v_rd_ff && wr_slot_ff == $past(slot_ff))
      else $error("transfer did not reach the read-modify-write stage");

   a_rmw_hold: assert property (@(posedge clock) disable iff (reset)
      v_rd_ff && !rdy_mag |=> v_rd_ff && $stable(wr_slot_ff) && $stable(rd_data))
      else $error("held window item lost its slot or read data");

   a_sel_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_selection == SEL_BOTH || rsp_selection == SEL_WIFI
                    || rsp_selection == SEL_LTE)
      else $error("invalid selection code offered");

endmodule

`default_nettype wire
